// ===== hw/rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted-array priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int PRI_W     = 16;
  localparam int ID_W      = 16;
  localparam int STAT_W    = 2;
  localparam int OCC_W     = 6;

  typedef logic signed [PRI_W-1:0] pri_t;
  typedef logic        [ID_W-1:0]  id_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a priority/id pair, compares it with
// the incoming priority and takes the new pair or a neighbor's pair.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic              occ,        // slot is below the held count
  input  spq_pkg::pri_t     new_pri,
  input  spq_pkg::id_t      new_id,
  input  logic              left_le,    // left neighbor keeps its entry
  input  spq_pkg::pri_t     left_pri,
  input  spq_pkg::id_t      left_id,
  input  spq_pkg::pri_t     right_pri,
  input  spq_pkg::id_t      right_id,
  output spq_pkg::pri_t     pri,
  output spq_pkg::id_t      id,
  output logic              le
);
  import spq_pkg::*;

  pri_t pri_r, pri_nxt;
  id_t  id_r,  id_nxt;

  // <= keeps equal priorities in arrival order
  assign le  = occ && (pri_r <= new_pri);
  assign pri = pri_r;
  assign id  = id_r;

  always_comb begin
    pri_nxt = pri_r;
    id_nxt  = id_r;
    if (ctl.rem) begin
      pri_nxt = right_pri;
      id_nxt  = right_id;
    end else if (ctl.ins && !le) begin
      if (left_le) begin
        pri_nxt = new_pri;
        id_nxt  = new_id;
      end else begin
        pri_nxt = left_pri;
        id_nxt  = left_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    pri_r <= pri_nxt;
    id_r  <= id_nxt;
  end

endmodule

// ===== hw/rtl/sorted_array_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_unit
// Bounded min-priority queue built as a chain of sorting cells.
// ----------------------------------------------------------------------------
// Input stream: in_tuser selects the action (0 insert, 1 remove the smallest
// priority); in_tdata carries the priority and identifier of an insert.
// Output stream: one result item per input item with status, the removed
// priority and identifier (zero unless a remove succeeded) and the count
// held afterwards.
// Every cell compares its entry with the incoming priority in parallel and
// shifts toward its neighbor in the same cycle: the result appears on
// out_tvalid the cycle after acceptance, and one item per cycle is taken
// while the result register drains.
// Equal priorities leave in arrival order; a full insert returns status 1,
// an empty remove status 2, and the queue is left unchanged by either.
// Reset clears the held count (the slots themselves are not cleared, only
// slots below the count are ever read) and drops any pending result.
// When out_tready is low with a result waiting, in_tready drops until the
// result is taken.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue_unit #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] priority_req, [31:16] item_id
  input  logic [0:0]  in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [1:0] status, [17:2] removed_priority,
                                  // [33:18] removed_id, [39:34] occupancy
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             vld_r, vld_nxt;
  status_t          stat_r, stat_nxt;
  pri_t             rpri_r, rpri_nxt;
  id_t              rid_r,  rid_nxt;
  logic [OCC_W-1:0] occ_r,  occ_nxt;
  logic [CNT_W+OCC_W-1:0] cnt_ext;

  pri_t      new_pri;
  id_t       new_id;
  logic      acc, is_rem, full, empty;
  cell_ctl_t ctl;

  pri_t cell_pri [DEPTH];
  id_t  cell_id  [DEPTH];
  logic cell_le  [DEPTH];

  assign new_pri   = pri_t'(in_tdata[15:0]);
  assign new_id    = in_tdata[31:16];
  assign in_tready = !vld_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign is_rem    = (in_tuser[0] == ACT_REMOVE);
  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign empty     = (cnt_r == '0);
  assign ctl.ins   = acc && !is_rem && !full;
  assign ctl.rem   = acc && is_rem && !empty;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic occ_g, left_le_g;
    pri_t left_pri_g, right_pri_g;
    id_t  left_id_g,  right_id_g;

    assign occ_g = (CNT_W'(g) < cnt_r);

    if (g == 0) begin : g_head
      assign left_le_g  = 1'b1;
      assign left_pri_g = new_pri;
      assign left_id_g  = new_id;
    end else begin : g_mid
      assign left_le_g  = cell_le[g-1];
      assign left_pri_g = cell_pri[g-1];
      assign left_id_g  = cell_id[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_pri_g = cell_pri[g];
      assign right_id_g  = cell_id[g];
    end else begin : g_body
      assign right_pri_g = cell_pri[g+1];
      assign right_id_g  = cell_id[g+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ_g),
      .new_pri   (new_pri),
      .new_id    (new_id),
      .left_le   (left_le_g),
      .left_pri  (left_pri_g),
      .left_id   (left_id_g),
      .right_pri (right_pri_g),
      .right_id  (right_id_g),
      .pri       (cell_pri[g]),
      .id        (cell_id[g]),
      .le        (cell_le[g])
    );
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    vld_nxt  = vld_r;
    stat_nxt = stat_r;
    rpri_nxt = rpri_r;
    rid_nxt  = rid_r;
    if (ctl.ins) cnt_nxt = cnt_r + CNT_W'(1);
    if (ctl.rem) cnt_nxt = cnt_r - CNT_W'(1);
    if (out_tready) vld_nxt = 1'b0;
    if (acc) begin
      vld_nxt  = 1'b1;
      stat_nxt = STAT_DONE;
      rpri_nxt = '0;
      rid_nxt  = '0;
      if (!is_rem && full) stat_nxt = STAT_FULL;
      if (is_rem && empty) stat_nxt = STAT_EMPTY;
      if (ctl.rem) begin
        rpri_nxt = cell_pri[0];
        rid_nxt  = cell_id[0];
      end
    end
  end

  assign cnt_ext = {{OCC_W{1'b0}}, cnt_nxt};
  assign occ_nxt = acc ? cnt_ext[OCC_W-1:0] : occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      vld_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      vld_r <= vld_nxt;
    end
    stat_r <= stat_nxt;
    rpri_r <= rpri_nxt;
    rid_r  <= rid_nxt;
    occ_r  <= occ_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {occ_r, rid_r, rpri_r, stat_r};

  // Assertions
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("held count above depth");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("insert did not bump count");

  a_full_stat: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !is_rem && full |=> vld_r && stat_r == STAT_FULL && cnt_r == CNT_W'(DEPTH))
    else $error("full insert not refused");

  if (DEPTH > 1) begin : g_sort_chk
    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      cnt_r >= CNT_W'(2) |-> cell_pri[0] <= cell_pri[1])
      else $error("head of queue out of order");
  end

endmodule
